### rtl/sndx_pkg.sv
// Shared types, constants and the Soundex letter table for the UTF-8 Soundex encoder.
// Used by the front classifier, the command queue and the back-end sequencer.
package sndx_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] LEAD2_LOW   = 8'hc2;
   localparam logic [7:0] LEAD2_HIGH  = 8'hdf;
   localparam logic [7:0] LEAD3_LOW   = 8'he0;
   localparam logic [7:0] LEAD3_HIGH  = 8'hef;
   localparam logic [7:0] LEAD4_LOW   = 8'hf0;
   localparam logic [7:0] LEAD4_HIGH  = 8'hf4;
   localparam logic [7:0] LEAD_E0     = 8'he0;
   localparam logic [7:0] LEAD_ED     = 8'hed;
   localparam logic [7:0] LEAD_F0     = 8'hf0;
   localparam logic [7:0] LEAD_F4     = 8'hf4;
   localparam logic [7:0] E0_MIN_NEXT = 8'ha0;
   localparam logic [7:0] ED_MAX_NEXT = 8'h9f;
   localparam logic [7:0] F0_MIN_NEXT = 8'h90;
   localparam logic [7:0] F4_MAX_NEXT = 8'h8f;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CASE_MASK   = 8'hdf;

   // Work for one input transaction: raw bytes, zero padding and the end item.
   typedef struct packed {
      logic [3:0][7:0] emit_bytes;
      logic [2:0]      emit_count;
      logic [1:0]      pad_count;
      logic            has_end;
      logic            status;
   } cmd_type;

   // Soundex digit of an upper-case letter; zero for letters that are skipped.
   function automatic logic [2:0] digit_of(input logic [7:0] up);
      logic [2:0] d;
      d = 3'd0;
      case (up) inside
         "B", "F", "P", "V":                     d = 3'd1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
         "D", "T":                               d = 3'd3;
         "L":                                    d = 3'd4;
         "M", "N":                               d = 3'd5;
         "R":                                    d = 3'd6;
         default:                                d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

### rtl/utf8_soundex_encoder.sv
// UTF-8 validating Soundex encoder, top level.
// Depends on sndx_pkg, sndx_front, sndx_queue and sndx_back.
//
// The req_ channel carries the string one byte per transaction; req_is_last marks the
// final byte and req_end_without_byte ends a string with no byte (empty input). The rsp_
// channel carries one transaction per result byte (rsp_byte_present high), then one end
// transaction (rsp_end_of_string high) whose rsp_status is 1 for invalid UTF-8. After an
// error status the receiver discards the bytes it already got for that string.
// A transaction is taken on an edge where valid is high and stall is low.
// Commands pass the queue, results the output register. Throughput: one byte per
// cycle while each byte gives at most one result and rsp_stall stays low. A byte that
// gives several results (a multi-byte first character, padding, the end transaction)
// yields one output transaction per result; the four-entry command queue between the
// front classifier and the output sequencer lets the input run ahead, and req_stall
// rises only when that queue is full. When the receiver stalls, the output register
// holds its transaction and the queue fills. Reset is synchronous and clears the string
// state, the queue and the output register; no transaction is pending afterward.
module utf8_soundex_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   input  logic       req_end_without_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_end_of_string,
   output logic       rsp_status
);
   import sndx_pkg::*;

   logic    accept;
   logic    push;
   logic    full;
   logic    pop;
   logic    not_empty;
   cmd_type front_cmd;
   cmd_type head_cmd;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   sndx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .is_last          (req_is_last),
      .end_without_byte (req_end_without_byte),
      .push             (push),
      .cmd              (front_cmd)
   );

   sndx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .full      (full),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (not_empty)
   );

   sndx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (head_cmd),
      .cmd_valid         (not_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_present  (rsp_byte_present),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_status        (rsp_status)
   );

endmodule

### rtl/sndx_front.sv
// Front classifier: validates UTF-8, tracks Soundex state and builds one command per byte.
// Depends on sndx_pkg for the command type, byte constants and the letter table.
module sndx_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             is_last,
   input  logic             end_without_byte,
   output logic             push,
   output sndx_pkg::cmd_type cmd
);
   import sndx_pkg::*;

   logic [1:0]      cont_ff, cont_in;
   logic [2:0]      len_ff, len_in;
   logic [7:0]      lead_ff, lead_in;
   logic [2:0][7:0] buf_ff, buf_in;
   logic            found_ff, found_in;
   logic [2:0]      prev_ff, prev_in;
   logic [1:0]      digits_ff, digits_in;
   logic            err_ff, err_in;

   logic       take;
   logic       fin;
   logic       is_upper;
   logic       is_lower;
   logic [7:0] up;
   logic [2:0] dig;
   logic [1:0] pos;
   logic       bad_second;

   assign take     = !end_without_byte && !err_ff;
   assign fin      = end_without_byte || is_last;
   assign is_upper = (data_byte >= "A") && (data_byte <= "Z");
   assign is_lower = (data_byte >= "a") && (data_byte <= "z");
   assign up       = is_lower ? (data_byte & CASE_MASK) : data_byte;
   assign dig      = digit_of(up);
   // Position of this continuation byte within its character.
   assign pos      = len_ff[1:0] - cont_ff;
   assign bad_second = (pos == 2'd1) &&
                       (((lead_ff == LEAD_E0) && (data_byte < E0_MIN_NEXT)) ||
                        ((lead_ff == LEAD_ED) && (data_byte > ED_MAX_NEXT)) ||
                        ((lead_ff == LEAD_F0) && (data_byte < F0_MIN_NEXT)) ||
                        ((lead_ff == LEAD_F4) && (data_byte > F4_MAX_NEXT)));

   always_comb begin
      cont_in   = cont_ff;
      len_in    = len_ff;
      lead_in   = lead_ff;
      buf_in    = buf_ff;
      found_in  = found_ff;
      prev_in   = prev_ff;
      digits_in = digits_ff;
      err_in    = err_ff;
      cmd       = '0;

      if (take) begin
         if (cont_ff == 2'd0) begin
            if (!data_byte[7]) begin
               if (is_upper || is_lower) begin
                  if (!found_ff) begin
                     cmd.emit_bytes[0] = up;
                     cmd.emit_count    = 3'd1;
                     found_in          = 1'b1;
                     prev_in           = dig;
                  end else if (dig != 3'd0) begin
                     if (dig != prev_ff) begin
                        cmd.emit_bytes[0] = CHAR_ZERO | {5'd0, dig};
                        cmd.emit_count    = 3'd1;
                        if (digits_ff != 2'd3) begin
                           digits_in = digits_ff + 2'd1;
                        end
                     end
                     prev_in = dig;
                  end
               end
            end else if ((data_byte >= LEAD2_LOW) && (data_byte <= LEAD2_HIGH)) begin
               len_in  = 3'd2;
               cont_in = 2'd1;
               lead_in = data_byte;
               buf_in  = {16'd0, data_byte};
            end else if ((data_byte >= LEAD3_LOW) && (data_byte <= LEAD3_HIGH)) begin
               len_in  = 3'd3;
               cont_in = 2'd2;
               lead_in = data_byte;
               buf_in  = {16'd0, data_byte};
            end else if ((data_byte >= LEAD4_LOW) && (data_byte <= LEAD4_HIGH)) begin
               len_in  = 3'd4;
               cont_in = 2'd3;
               lead_in = data_byte;
               buf_in  = {16'd0, data_byte};
            end else begin
               err_in = 1'b1;
            end
         end else if ((data_byte[7:6] != 2'b10) || bad_second) begin
            err_in = 1'b1;
         end else begin
            if (pos != 2'd3) begin
               buf_in[pos] = data_byte;
            end
            cont_in = cont_ff - 2'd1;
            // The final byte of a character always sits in the top slot it reaches.
            if ((cont_ff == 2'd1) && !found_ff) begin
               cmd.emit_bytes[2:0] = buf_in;
               cmd.emit_bytes[3]   = data_byte;
               cmd.emit_count      = len_ff;
               found_in            = 1'b1;
            end
         end
      end

      if (fin) begin
         if (cont_in != 2'd0) begin
            err_in = 1'b1;
         end
         if (!err_in && found_in) begin
            cmd.pad_count = 2'd3 - digits_in;
         end
         cmd.has_end = 1'b1;
         cmd.status  = err_in;
         cont_in   = '0;
         len_in    = '0;
         lead_in   = '0;
         buf_in    = '0;
         found_in  = 1'b0;
         prev_in   = '0;
         digits_in = '0;
         err_in    = 1'b0;
      end
   end

   assign push = accept && ((cmd.emit_count != 3'd0) || cmd.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff   <= '0;
         len_ff    <= '0;
         lead_ff   <= '0;
         buf_ff    <= '0;
         found_ff  <= 1'b0;
         prev_ff   <= '0;
         digits_ff <= '0;
         err_ff    <= 1'b0;
      end else if (accept) begin
         cont_ff   <= cont_in;
         len_ff    <= len_in;
         lead_ff   <= lead_in;
         buf_ff    <= buf_in;
         found_ff  <= found_in;
         prev_ff   <= prev_in;
         digits_ff <= digits_in;
         err_ff    <= err_in;
      end
   end

endmodule

### rtl/sndx_queue.sv
// Short command queue between the front classifier and the back-end sequencer.
// Depends on sndx_pkg for the command type and the queue depth.
module sndx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sndx_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output sndx_pkg::cmd_type head_cmd,
   output logic              not_empty
);
   import sndx_pkg::*;

   cmd_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/sndx_back.sv
// Back-end sequencer: expands queued commands into results, one per cycle unless stalled.
// Depends on sndx_pkg for the command type and the padding character.
module sndx_back (
   input  logic              clock,
   input  logic              reset,
   input  sndx_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_present,
   output logic              rsp_end_of_string,
   output logic              rsp_status
);
   import sndx_pkg::*;

   logic [2:0] step_ff;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       present_ff, present_in;
   logic       end_ff, end_in;
   logic       status_ff, status_in;
   logic [3:0] total;
   logic [3:0] step_ext;
   logic [3:0] bytes_end;
   logic       load;
   logic       last_step;

   assign total     = {1'b0, cmd.emit_count} + {2'b0, cmd.pad_count} + {3'b0, cmd.has_end};
   assign bytes_end = {1'b0, cmd.emit_count} + {2'b0, cmd.pad_count};
   assign step_ext  = {1'b0, step_ff};
   assign load      = cmd_valid && (!valid_ff || !rsp_stall);
   assign last_step = (step_ext == total - 4'd1);
   assign pop       = load && last_step;

   // Raw bytes first, then zero padding, then the end transaction.
   always_comb begin
      byte_in    = 8'd0;
      present_in = 1'b1;
      end_in     = 1'b0;
      status_in  = 1'b0;
      if (step_ext < {1'b0, cmd.emit_count}) begin
         byte_in = cmd.emit_bytes[step_ff[1:0]];
      end else if (step_ext < bytes_end) begin
         byte_in = CHAR_ZERO;
      end else begin
         present_in = 1'b0;
         end_in     = 1'b1;
         status_in  = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         step_ff  <= last_step ? 3'd0 : step_ff + 3'd1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= byte_in;
         present_ff <= present_in;
         end_ff     <= end_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_byte_present  = present_ff;
   assign rsp_end_of_string = end_ff;
   assign rsp_status        = status_ff;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_soundex_encoder: directed strings, then random UTF-8 text.
// Depends on sndx_pkg for the UTF-8 boundary constants and on the encoder RTL.

module testbench;
   import sndx_pkg::*;

   localparam int RANDOM_ITEMS   = 480;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       end_of_string;
      logic       status;
   } code_item_type;

   // One directed transaction; rows marked fixed carry an end item typed in by hand.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       bare;
      logic       fixed;
      logic       end_status;
   } stim_row_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE}
      stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       req_end_without_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_present;
   logic       rsp_end_of_string;
   logic       rsp_status;

   utf8_soundex_encoder u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_is_last          (req_is_last),
      .req_end_without_byte (req_end_without_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_present     (rsp_byte_present),
      .rsp_end_of_string    (rsp_end_of_string),
      .rsp_status           (rsp_status)
   );

   always #2 clock = ~clock;

   code_item_type  pending_code[$];
   logic [7:0]     string_bytes[$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             items_sent = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [6:0]     mode_left = '0;

   // String state of the encoder as the bench sees it.
   logic [1:0]  cont_left = '0;
   logic [2:0]  char_len = '0;
   logic [7:0]  lead = '0;
   logic [31:0] first_buf = '0;
   logic        started = 1'b0;
   logic [2:0]  last_digit = '0;
   logic [1:0]  digit_count = '0;
   logic        bad_utf8 = 1'b0;

   stim_row_type directed_rows [0:24] = '{
      {8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
      {8'hff, 1'b1, 1'b0, 1'b1, 1'b1},
      {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h7f, 1'b1, 1'b0, 1'b1, 1'b0},
      {8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h62, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h42, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h68, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h70, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h5a, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'he0, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'ha0, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'hed, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'ha0, 1'b1, 1'b0, 1'b1, 1'b1},
      {8'hf4, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h90, 1'b1, 1'b0, 1'b1, 1'b1},
      {8'hf0, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h8f, 1'b1, 1'b0, 1'b1, 1'b1},
      {8'hc2, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
      {8'hf4, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h8f, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'hbf, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'hbf, 1'b1, 1'b0, 1'b0, 1'b0}
   };

   function automatic void push_code(input logic [7:0] b, input logic present,
                                     input logic is_end, input logic st);
      code_item_type c;
      c.out_byte      = b;
      c.byte_present  = present;
      c.end_of_string = is_end;
      c.status        = st;
      pending_code.push_back(c);
   endfunction

   function automatic logic [2:0] soundex_digit(input logic [7:0] up);
      logic [2:0] d;
      case (up)
         "B", "F", "P", "V":                     d = 3'd1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
         "D", "T":                               d = 3'd3;
         "L":                                    d = 3'd4;
         "M", "N":                               d = 3'd5;
         "R":                                    d = 3'd6;
         default:                                d = 3'd0;
      endcase
      return d;
   endfunction

   function automatic void take_letter(input logic [7:0] b);
      logic [7:0] up;
      logic [2:0] d;
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
         up = (b >= "a") ? b - 8'd32 : b;
         d  = soundex_digit(up);
         if (!started) begin
            push_code(up, 1'b1, 1'b0, 1'b0);
            started    = 1'b1;
            last_digit = d;
         end else if (d != 3'd0) begin
            if (d != last_digit) begin
               push_code(CHAR_ZERO + {5'd0, d}, 1'b1, 1'b0, 1'b0);
               if (digit_count != 2'd3)
                  digit_count = digit_count + 2'd1;
            end
            last_digit = d;
         end
      end
   endfunction

   function automatic void take_utf8(input logic [7:0] b);
      logic [2:0] len;
      logic [2:0] offset;
      logic [1:0] pos;
      logic       rejected;
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            take_letter(b);
         end else begin
            if (b >= LEAD2_LOW && b <= LEAD2_HIGH)
               len = 3'd2;
            else if (b >= LEAD3_LOW && b <= LEAD3_HIGH)
               len = 3'd3;
            else if (b >= LEAD4_LOW && b <= LEAD4_HIGH)
               len = 3'd4;
            else
               len = 3'd0;
            if (len == 3'd0) begin
               bad_utf8 = 1'b1;
            end else begin
               char_len  = len;
               lead      = b;
               cont_left = 2'(len - 3'd1);
               first_buf = {24'd0, b};
            end
         end
      end else begin
         offset   = char_len - {1'b0, cont_left};
         pos      = offset[1:0];
         // Only the second byte of a character carries the overlong and range limits.
         rejected = (b[7:6] != 2'b10) ||
                    (pos == 2'd1 && ((lead == LEAD_E0 && b < E0_MIN_NEXT) ||
                                     (lead == LEAD_ED && b > ED_MAX_NEXT) ||
                                     (lead == LEAD_F0 && b < F0_MIN_NEXT) ||
                                     (lead == LEAD_F4 && b > F4_MAX_NEXT)));
         if (rejected) begin
            bad_utf8 = 1'b1;
         end else begin
            first_buf = first_buf | ({24'd0, b} << (8 * pos));
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0 && !started) begin
               for (int i = 0; i < char_len; i++)
                  push_code(first_buf[8*i +: 8], 1'b1, 1'b0, 1'b0);
               started = 1'b1;
            end
         end
      end
   endfunction

   function automatic void close_string();
      if (cont_left != 2'd0)
         bad_utf8 = 1'b1;
      if (!bad_utf8 && started) begin
         while (digit_count != 2'd3) begin
            push_code(CHAR_ZERO, 1'b1, 1'b0, 1'b0);
            digit_count = digit_count + 2'd1;
         end
      end
      push_code(8'h00, 1'b0, 1'b1, bad_utf8);
      cont_left   = '0;
      char_len    = '0;
      lead        = '0;
      first_buf   = '0;
      started     = 1'b0;
      last_digit  = '0;
      digit_count = '0;
      bad_utf8    = 1'b0;
   endfunction

   // Returns how many result transactions the byte adds to the expected stream.
   function automatic int encode_item(input logic [7:0] b, input logic last, input logic bare);
      int depth;
      depth = pending_code.size();
      if (bare) begin
         close_string();
      end else begin
         if (!bad_utf8)
            take_utf8(b);
         if (last)
            close_string();
      end
      return pending_code.size() - depth;
   endfunction

   function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
      logic [7:0] v;
      case ($urandom_range(0, 3))
         0:       v = lo;
         1:       v = hi;
         default: v = 8'($urandom_range(lo, hi));
      endcase
      return v;
   endfunction

   task automatic make_string();
      int         chars;
      int         kind;
      int         len;
      bit         noise;
      logic [7:0] lead_b;
      logic [7:0] lo;
      logic [7:0] hi;
      string_bytes.delete();
      chars = $urandom_range(0, 9);
      noise = ($urandom_range(0, 9) == 0);
      for (int c = 0; c < chars; c++) begin
         kind = $urandom_range(0, 11);
         if (noise) begin
            string_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (kind <= 5) begin
            string_bytes.push_back(8'($urandom_range(0, 25)) +
                                   ($urandom_range(0, 1) ? 8'h61 : 8'h41));
         end else if (kind == 6) begin
            string_bytes.push_back(8'($urandom_range(0, 127)));
         end else if (kind <= 9) begin
            len = kind - 5;
            case (len)
               2: lead_b = pick_in(LEAD2_LOW, LEAD2_HIGH);
               3: lead_b = ($urandom_range(0, 2) == 0) ? LEAD_ED : pick_in(LEAD3_LOW, LEAD3_HIGH);
               default: lead_b = pick_in(LEAD4_LOW, LEAD4_HIGH);
            endcase
            lo = 8'h80;
            hi = 8'hbf;
            if (lead_b == LEAD_E0) lo = E0_MIN_NEXT;
            if (lead_b == LEAD_ED) hi = ED_MAX_NEXT;
            if (lead_b == LEAD_F0) lo = F0_MIN_NEXT;
            if (lead_b == LEAD_F4) hi = F4_MAX_NEXT;
            string_bytes.push_back(lead_b);
            string_bytes.push_back(pick_in(lo, hi));
            for (int k = 2; k < len; k++)
               string_bytes.push_back(pick_in(8'h80, 8'hbf));
         end else if (kind == 10) begin
            // A stray byte with the top bit set: continuation, bad lead or lead.
            string_bytes.push_back(8'($urandom_range(128, 255)));
         end else begin
            string_bytes.push_back(pick_in(LEAD2_LOW, LEAD4_HIGH));
            string_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      if (string_bytes.size() > 1 && $urandom_range(0, 11) == 0)
         void'(string_bytes.pop_back());
   endtask

   task automatic send_item(input logic [7:0] b, input logic last, input logic bare,
                            output int produced);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_valid            <= 1'b1;
      req_data_byte        <= b;
      req_is_last          <= last;
      req_end_without_byte <= bare;
      do @(posedge clock); while (req_stall);
      produced   = encode_item(b, last, bare);
      items_sent = items_sent + 1;
   endtask

   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_code.size() != 0);
   endtask

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Receiver: switches between stall patterns, each picked at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left  <= '0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= 7'($urandom_range(8, 100));
         end else begin
            mode_left <= mode_left - 7'd1;
         end
         case (stall_mode)
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      code_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_code.size() == 0) begin
            $error("unexpected result transaction: out_byte %h end_of_string %b",
                   rsp_out_byte, rsp_end_of_string);
            mismatch_count++;
         end else begin
            want = pending_code.pop_front();
            check_field("rsp_out_byte", want.out_byte, rsp_out_byte);
            check_field("rsp_byte_present", {7'd0, want.byte_present}, {7'd0, rsp_byte_present});
            check_field("rsp_end_of_string", {7'd0, want.end_of_string},
                        {7'd0, rsp_end_of_string});
            check_field("rsp_status", {7'd0, want.status}, {7'd0, rsp_status});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int            produced;
      bit            paused;
      bit            bare_end;
      stim_row_type  row;
      code_item_type dropped;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.data, row.last, row.bare, produced);
         if (row.fixed) begin
            // The end transaction of these rows is known by inspection.
            repeat (produced) dropped = pending_code.pop_back();
            push_code(8'h00, 1'b0, 1'b1, row.end_status);
         end
      end
      wait_drained();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         make_string();
         if (string_bytes.size() == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, produced);
         end else begin
            bare_end = ($urandom_range(0, 3) == 0);
            foreach (string_bytes[i])
               send_item(string_bytes[i], !bare_end && (i == string_bytes.size() - 1), 1'b0,
                         produced);
            if (bare_end)
               send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, produced);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
